### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh - shared concurrent assertion macros
// Both macros sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/kid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kid_pkg - shared types and codes for the k-mer interval directory
// Status codes, action codes, register indexes and inter-module flag structs.
// ----------------------------------------------------------------------------
package kid_pkg;

    // Field widths fixed by the interface
    localparam int ACTION_W     = 2;
    localparam int SYMBOL_W     = 8;
    localparam int ROW_IN_W     = 32;
    localparam int STATUS_W     = 3;
    localparam int REC_COUNT_W  = 40;
    localparam int FILL_COUNT_W = 21;
    localparam int KLEN_W       = 4;
    localparam int BASE_W       = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    // Command queue between front and back
    localparam int QUEUE_DEPTH  = 4;

    // Input actions
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TEXT   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // Result status; also used as the command kind in the queue.
    // A lookup travels as STATUS_HIT and is resolved to hit or empty in the back.
    localparam logic [STATUS_W-1:0] STATUS_PENDING  = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_RECORDED = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_SKIPPED  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_ROW_ERR  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_HIT      = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd5;
    localparam logic [STATUS_W-1:0] STATUS_NONE     = 3'd6;
    localparam logic [STATUS_W-1:0] STATUS_CLEARED  = 3'd7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUFFIX_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_A_CODE  = 2'd2;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_flags_t;

    typedef struct packed {
        logic clearing;
    } back_flags_t;

endpackage

### design/kid_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kid_fifo - short command queue between front and back
// Register-based FIFO; head entry is always presented on rd_data.
// ----------------------------------------------------------------------------
module kid_fifo #(
    parameter int WIDTH = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [WIDTH-1:0]        wr_data,
    input  logic                    pop,
    output logic [WIDTH-1:0]        rd_data,
    output kid_pkg::queue_flags_t   flags
);
    import kid_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign flags.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign flags.empty = (count_reg == '0);
    assign do_push     = push && !flags.full;
    assign do_pop      = pop && !flags.empty;
    assign rd_data     = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### design/kid_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kid_front - input classifier for the k-mer interval directory
// Holds the configuration registers and the rolling text and query keys,
// classifies each transaction and queues a command for the back end.
// ----------------------------------------------------------------------------
module kid_front #(
    parameter int MAX_K = 10
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [kid_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [kid_pkg::CFG_DATA_W-1:0]          cfg_wdata,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [kid_pkg::ACTION_W-1:0]            action,
    input  logic [kid_pkg::SYMBOL_W-1:0]            symbol,
    input  logic                                    contig_start,
    input  logic [kid_pkg::ROW_IN_W-1:0]            suffix_row,
    input  logic                                    query_last,
    input  kid_pkg::queue_flags_t                   q_flags,
    input  kid_pkg::back_flags_t                    b_flags,
    output logic                                    cmd_push,
    output logic [kid_pkg::STATUS_W+2*MAX_K+kid_pkg::ROW_IN_W-1:0] cmd_data
);
    import kid_pkg::*;

    localparam int KEY_W = 2 * MAX_K;

    // Configuration registers
    logic [KLEN_W-1:0]   kmer_length_reg;
    logic [ROW_IN_W-1:0] suffix_count_reg;
    logic [BASE_W-1:0]   base_a_code_reg;

    // Rolling text and query state
    logic [KEY_W-1:0]  rolling_key_reg, rolling_key_next;
    logic [KLEN_W-1:0] window_fill_reg, window_fill_next;
    logic [KEY_W-1:0]  query_key_reg, query_key_next;
    logic [KLEN_W-1:0] query_fill_reg, query_fill_next;
    logic              query_bad_reg, query_bad_next;

    logic              accept;
    logic [KLEN_W-1:0] k_act;
    logic [KEY_W-1:0]  kmask;
    logic              canonical;
    logic [1:0]        sym_val;
    logic [SYMBOL_W-1:0] sym_off;
    logic [KEY_W-1:0]  key_base;
    logic [KLEN_W-1:0] fill_base;
    logic [STATUS_W-1:0] cmd_kind;
    logic [KEY_W-1:0]  cmd_key;

    assign in_ready = !q_flags.full && !b_flags.clearing;
    assign accept   = in_valid && in_ready;
    assign cmd_push = accept;
    assign cmd_data = {cmd_kind, cmd_key, suffix_row};

    // Active k: out-of-range lengths act as no index
    assign k_act = (kmer_length_reg > KLEN_W'(MAX_K)) ? '0 : kmer_length_reg;

    always_comb
    begin
        for (int i = 0; i < KEY_W; i++)
        begin
            kmask[i] = (5'(i) < {k_act, 1'b0});
        end
    end

    // Symbol decode: A..A+3 map to 0..3
    assign canonical = ({1'b0, symbol} >= {1'b0, base_a_code_reg})
                    && ({1'b0, symbol} <= ({1'b0, base_a_code_reg} + 9'd3));
    assign sym_off   = symbol - base_a_code_reg;
    assign sym_val   = sym_off[1:0];

    assign key_base  = contig_start ? '0 : rolling_key_reg;
    assign fill_base = contig_start ? '0 : window_fill_reg;

    // Classification and next rolling state
    always_comb
    begin
        rolling_key_next = rolling_key_reg;
        window_fill_next = window_fill_reg;
        query_key_next   = query_key_reg;
        query_fill_next  = query_fill_reg;
        query_bad_next   = query_bad_reg;
        cmd_kind         = STATUS_PENDING;
        cmd_key          = rolling_key_reg;
        unique case (action)
            ACT_CLEAR:
            begin
                rolling_key_next = '0;
                window_fill_next = '0;
                query_key_next   = '0;
                query_fill_next  = '0;
                query_bad_next   = 1'b0;
                cmd_kind         = STATUS_CLEARED;
            end
            ACT_TEXT:
            begin
                if (!canonical)
                begin
                    rolling_key_next = '0;
                    window_fill_next = '0;
                    cmd_kind         = STATUS_SKIPPED;
                end
                else
                begin
                    rolling_key_next = KEY_W'({key_base, sym_val}) & kmask;
                    window_fill_next = (fill_base < k_act) ? fill_base + 1'b1 : fill_base;
                    priority if (k_act == '0)
                    begin
                        cmd_kind = STATUS_SKIPPED;
                    end
                    else if (window_fill_next < k_act)
                    begin
                        cmd_kind = STATUS_PENDING;
                    end
                    else if (suffix_row >= suffix_count_reg)
                    begin
                        cmd_kind = STATUS_ROW_ERR;
                    end
                    else
                    begin
                        cmd_kind = STATUS_RECORDED;
                    end
                end
                cmd_key = rolling_key_next;
            end
            ACT_QUERY:
            begin
                if (query_fill_reg < k_act)
                begin
                    if (!canonical)
                    begin
                        query_bad_next = 1'b1;
                    end
                    else
                    begin
                        query_key_next = KEY_W'({query_key_reg, sym_val});
                    end
                    query_fill_next = query_fill_reg + 1'b1;
                end
                cmd_key = query_key_next;
                if (query_last)
                begin
                    if (k_act == '0 || query_fill_next < k_act || query_bad_next)
                    begin
                        cmd_kind = STATUS_NONE;
                    end
                    else
                    begin
                        cmd_kind = STATUS_HIT;
                    end
                    query_key_next  = '0;
                    query_fill_next = '0;
                    query_bad_next  = 1'b0;
                end
            end
            ACT_UNUSED:
            begin
                cmd_kind = STATUS_PENDING;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg  <= '0;
            suffix_count_reg <= ROW_IN_W'(1);
            base_a_code_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KMER_LENGTH:  kmer_length_reg  <= cfg_wdata[KLEN_W-1:0];
                CFG_SUFFIX_COUNT: suffix_count_reg <= cfg_wdata[ROW_IN_W-1:0];
                CFG_BASE_A_CODE:  base_a_code_reg  <= cfg_wdata[BASE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Rolling state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rolling_key_reg <= '0;
            window_fill_reg <= '0;
            query_key_reg   <= '0;
            query_fill_reg  <= '0;
            query_bad_reg   <= 1'b0;
        end
        else if (accept)
        begin
            rolling_key_reg <= rolling_key_next;
            window_fill_reg <= window_fill_next;
            query_key_reg   <= query_key_next;
            query_fill_reg  <= query_fill_next;
            query_bad_reg   <= query_bad_next;
        end
    end

endmodule

### design/kid_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kid_back - directory store and result stage
// Executes queued commands against the entry memory (read, then update),
// keeps the counters, holds the output register and runs the clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kid_back #(
    parameter int MAX_K    = 10,
    parameter int ROW_BITS = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  kid_pkg::queue_flags_t                   q_flags,
    input  logic [kid_pkg::STATUS_W+2*MAX_K+kid_pkg::ROW_IN_W-1:0] q_data,
    output logic                                    pop,
    output kid_pkg::back_flags_t                    b_flags,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [kid_pkg::STATUS_W-1:0]            out_status,
    output logic [kid_pkg::ROW_IN_W-1:0]            out_begin,
    output logic [kid_pkg::ROW_IN_W-1:0]            out_end,
    output logic [kid_pkg::REC_COUNT_W-1:0]         out_indexed,
    output logic [kid_pkg::FILL_COUNT_W-1:0]        out_nonempty
);
    import kid_pkg::*;

    localparam int KEY_W = 2 * MAX_K;
    localparam int DEPTH = 1 << KEY_W;
    localparam int ENT_W = 1 + 2 * ROW_BITS;
    localparam int WB    = (ROW_BITS > ROW_IN_W + 1) ? ROW_BITS : ROW_IN_W + 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    // Entry store: {valid, end, begin}
    logic [ENT_W-1:0] dir_mem [DEPTH];
    logic [ENT_W-1:0] entry_q_reg;
    logic             mem_we;
    logic [KEY_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;

    logic [1:0]       state_reg, state_next;
    logic [KEY_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [STATUS_W+KEY_W+ROW_IN_W-1:0] cmd_reg;
    logic [REC_COUNT_W-1:0]  recorded_reg, recorded_next;
    logic [FILL_COUNT_W-1:0] filled_reg, filled_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ROW_IN_W-1:0] out_begin_reg, out_begin_next;
    logic [ROW_IN_W-1:0] out_end_reg, out_end_next;

    logic                out_free;
    logic                exec;
    logic [STATUS_W-1:0] kind;
    logic [KEY_W-1:0]    key;
    logic [ROW_IN_W-1:0] row;
    logic [KEY_W-1:0]    head_key;
    logic                e_valid;
    logic [ROW_BITS-1:0] e_begin;
    logic [ROW_BITS-1:0] e_end;
    logic [WB-1:0]       row_w;
    logic [WB-1:0]       row1_w;
    logic [ROW_BITS-1:0] r0;
    logic [ROW_BITS-1:0] r1;
    logic [ROW_BITS-1:0] new_begin;
    logic [ROW_BITS-1:0] new_end;
    logic [WB-1:0]       begin_w;
    logic [WB-1:0]       end_w;

    // Command and entry decode
    assign {kind, key, row} = cmd_reg;
    assign head_key = q_data[ROW_IN_W +: KEY_W];
    assign e_valid  = entry_q_reg[ENT_W-1];
    assign e_end    = entry_q_reg[2*ROW_BITS-1:ROW_BITS];
    assign e_begin  = entry_q_reg[ROW_BITS-1:0];
    assign row_w    = WB'(row);
    assign row1_w   = row_w + WB'(1);
    assign r0       = row_w[ROW_BITS-1:0];
    assign r1       = row1_w[ROW_BITS-1:0];
    assign new_begin = (!e_valid || r0 < e_begin) ? r0 : e_begin;
    assign new_end   = (!e_valid || r1 > e_end) ? r1 : e_end;
    assign begin_w   = WB'(e_begin);
    assign end_w     = WB'(e_end);

    // Handshake-side control
    assign out_free = !out_valid_reg || out_ready;
    assign pop      = (state_reg == ST_IDLE) && !q_flags.empty;
    assign exec     = (state_reg == ST_EXEC) && out_free;
    assign b_flags.clearing = (state_reg == ST_CLEAR);

    // Memory write port: sweep or record update
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = key;
        mem_wdata = {1'b1, new_end, new_begin};
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_reg;
            mem_wdata = '0;
        end
        else if (exec && kind == STATUS_RECORDED)
        begin
            mem_we = 1'b1;
        end
    end

    // Sequencer, counters and result
    always_comb
    begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        recorded_next   = recorded_reg;
        filled_next     = filled_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_begin_next  = out_begin_reg;
        out_end_next    = out_end_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                sweep_addr_next = sweep_addr_reg + 1'b1;
                if (&sweep_addr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec)
                begin
                    state_next      = ST_IDLE;
                    out_valid_next  = 1'b1;
                    out_status_next = kind;
                    out_begin_next  = '0;
                    out_end_next    = '0;
                    unique case (kind)
                        STATUS_CLEARED:
                        begin
                            recorded_next   = '0;
                            filled_next     = '0;
                            state_next      = ST_CLEAR;
                            sweep_addr_next = '0;
                        end
                        STATUS_RECORDED:
                        begin
                            if (recorded_reg != '1)
                            begin
                                recorded_next = recorded_reg + 1'b1;
                            end
                            if (!e_valid && filled_reg != '1)
                            begin
                                filled_next = filled_reg + 1'b1;
                            end
                        end
                        STATUS_HIT:
                        begin
                            if (e_valid)
                            begin
                                out_begin_next = begin_w[ROW_IN_W-1:0];
                                out_end_next   = end_w[ROW_IN_W-1:0];
                            end
                            else
                            begin
                                out_status_next = STATUS_EMPTY;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            sweep_addr_reg <= '0;
            recorded_reg   <= '0;
            filled_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            recorded_reg   <= recorded_next;
            filled_reg     <= filled_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_begin_reg  <= out_begin_next;
        out_end_reg    <= out_end_next;
        if (pop)
        begin
            cmd_reg <= q_data;
        end
    end

    // Entry memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dir_mem[mem_waddr] <= mem_wdata;
        end
        if (pop)
        begin
            entry_q_reg <= dir_mem[head_key];
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_begin    = out_begin_reg;
    assign out_end      = out_end_reg;
    assign out_indexed  = recorded_reg;
    assign out_nonempty = filled_reg;

    // Checks
    `ASSERT_IMPLY(a_no_pop_in_clear, state_reg == ST_CLEAR, !pop, "queue popped during clear pass")
    `ASSERT_IMPLY(a_clear_writes_invalid, state_reg == ST_CLEAR,
        mem_we && !mem_wdata[ENT_W-1], "clear pass left an entry valid")
    `ASSERT_NEXT(a_clear_resets, exec && kind == STATUS_CLEARED,
        state_reg == ST_CLEAR && recorded_reg == '0 && filled_reg == '0
        && out_status_reg == STATUS_CLEARED, "clear command did not reset block")
    `ASSERT_IMPLY(a_filled_le_recorded, 1'b1,
        REC_COUNT_W'(filled_reg) <= recorded_reg, "more entries filled than recorded")

endmodule

### design/kmer_interval_directory_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_interval_directory_top - k-mer interval directory
// Builds a directory of suffix-array intervals keyed by 2-bit packed k-mers
// and answers k-mer lookups against it.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: one text symbol, query symbol or clear per
//   transaction; tuser carries the action, tlast marks a query's last symbol.
//   Output stream m_axis: exactly one result per input transaction, in order.
//   Config port: cfg_we/cfg_index/cfg_wdata, written only while idle.
// Timing:
//   The front accepts one transaction per cycle, while the queue is not full
//   and no clearing pass runs, into a 4-entry command queue. The back handles
//   one transaction at a time: entry memory read when it pops the command,
//   then update and registered result, before it pops the next command.
// Reset and clear:
//   After reset, and after each clear action, a clearing pass writes every
//   one of the 4^MAX_K entries, one per cycle (1,048,576 entries at MAX_K=10);
//   s_axis_tready stays low during the pass.
// Backpressure:
//   A stalled m_axis holds the result; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module kmer_interval_directory_top #(
    parameter int MAX_K    = 10,
    parameter int ROW_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [kid_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kid_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [47:0]                     s_axis_tdata,  // symbol[7:0], contig_start[8], suffix_row[40:9]
    input  logic [kid_pkg::ACTION_W-1:0]    s_axis_tuser,  // action
    input  logic                            s_axis_tlast,  // query_last
    // Result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [127:0]                    m_axis_tdata,  // interval_begin[31:0], interval_end[63:32], indexed_total[103:64], nonempty_total[124:104]
    output logic [kid_pkg::STATUS_W-1:0]    m_axis_tuser   // status
);
    import kid_pkg::*;

    localparam int CMD_W = STATUS_W + 2 * MAX_K + ROW_IN_W;

    queue_flags_t        q_flags;
    back_flags_t         b_flags;
    logic                cmd_push;
    logic [CMD_W-1:0]    cmd_data;
    logic                cmd_pop;
    logic [CMD_W-1:0]    head_data;
    logic [ROW_IN_W-1:0]     res_begin;
    logic [ROW_IN_W-1:0]     res_end;
    logic [REC_COUNT_W-1:0]  res_indexed;
    logic [FILL_COUNT_W-1:0] res_nonempty;

    kid_front #(
        .MAX_K (MAX_K)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .action       (s_axis_tuser),
        .symbol       (s_axis_tdata[7:0]),
        .contig_start (s_axis_tdata[8]),
        .suffix_row   (s_axis_tdata[40:9]),
        .query_last   (s_axis_tlast),
        .q_flags      (q_flags),
        .b_flags      (b_flags),
        .cmd_push     (cmd_push),
        .cmd_data     (cmd_data)
    );

    kid_fifo #(
        .WIDTH (CMD_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_data),
        .pop     (cmd_pop),
        .rd_data (head_data),
        .flags   (q_flags)
    );

    kid_back #(
        .MAX_K    (MAX_K),
        .ROW_BITS (ROW_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_flags      (q_flags),
        .q_data       (head_data),
        .pop          (cmd_pop),
        .b_flags      (b_flags),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_status   (m_axis_tuser),
        .out_begin    (res_begin),
        .out_end      (res_end),
        .out_indexed  (res_indexed),
        .out_nonempty (res_nonempty)
    );

    // Result packing, padded to whole bytes
    assign m_axis_tdata = {3'b000, res_nonempty, res_indexed, res_end, res_begin};

endmodule

### tb/sv/tb_kmer_interval_directory_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kmer_interval_directory_top - self-checking bench for the k-mer directory
// Streams text, query, clear and unused transactions into the directory and
// checks every result against an in-bench model of the directory, its rolling
// keys and its counters. Directed cases come first, then random traffic under
// three sender/receiver stall mixes and several register settings.
// ----------------------------------------------------------------------------
module tb_kmer_interval_directory_top;
    import kid_pkg::*;

    localparam int DIR_MAX_K = 10;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SYMBOL_W-1:0] symbol;
        logic                contig_start;
        logic [ROW_IN_W-1:0] suffix_row;
        logic                query_last;
    } dir_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [31:0]             ibegin;
        logic [31:0]             iend;
        logic [REC_COUNT_W-1:0]  indexed;
        logic [FILL_COUNT_W-1:0] nonempty;
    } dir_answer_t;

    // DUT connections, all known from time zero
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [47:0]            s_axis_tdata = '0;
    logic [ACTION_W-1:0]    s_axis_tuser = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [127:0]           m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;

    // Mirror of the registers and the directory state
    logic [KLEN_W-1:0]       mir_kmer_len = '0;
    logic [31:0]             mir_suffix_count = 32'd1;
    logic [BASE_W-1:0]       mir_base = '0;
    logic [31:0]             dir_begin [int];
    logic [31:0]             dir_end [int];
    logic [19:0]             roll_key = '0;
    int unsigned             roll_fill = 0;
    logic [19:0]             qry_key = '0;
    int unsigned             qry_fill = 0;
    bit                      qry_bad = 1'b0;
    logic [REC_COUNT_W-1:0]  rec_count = '0;
    logic [FILL_COUNT_W-1:0] fill_count = '0;

    // Answers still owed by the DUT, oldest first
    dir_answer_t awaited_answers[$];
    dir_answer_t head_answer;

    // Stimulus knobs and bookkeeping
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic [7:0]  text_trail[$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          results_checked = 0;
    int          status_seen [8];

    kmer_interval_directory_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Run limit: three clearing passes plus stalled traffic fit well inside
    initial
    begin
        #150_000_000;
        $display("FAIL kmer_interval_directory_top");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Directory model
    // ------------------------------------------------------------------------
    function automatic int active_kmer_len();
        return (mir_kmer_len > DIR_MAX_K) ? 0 : int'(mir_kmer_len);
    endfunction

    function automatic bit is_canonical(logic [7:0] sym);
        return ({1'b0, sym} >= {1'b0, mir_base}) && ({1'b0, sym} <= {1'b0, mir_base} + 9'd3);
    endfunction

    function automatic dir_answer_t directory_answer(dir_item_t it);
        int          k;
        bit          canon;
        logic [1:0]  code;
        logic [19:0] kmask;
        int          idx;
        logic [31:0] row_next;
        dir_answer_t a;
        a        = '0;
        k        = active_kmer_len();
        canon    = is_canonical(it.symbol);
        code     = 2'(it.symbol - mir_base);
        kmask    = 20'((64'd1 << (2 * k)) - 64'd1);
        row_next = it.suffix_row + 32'd1;
        case (it.action)
            ACT_CLEAR:
            begin
                dir_begin.delete();
                dir_end.delete();
                roll_key   = '0;
                roll_fill  = 0;
                qry_key    = '0;
                qry_fill   = 0;
                qry_bad    = 1'b0;
                rec_count  = '0;
                fill_count = '0;
                a.status   = STATUS_CLEARED;
            end
            ACT_TEXT:
            begin
                if (it.contig_start)
                begin
                    roll_key  = '0;
                    roll_fill = 0;
                end
                if (!canon)
                begin
                    roll_key  = '0;
                    roll_fill = 0;
                    a.status  = STATUS_SKIPPED;
                end
                else
                begin
                    roll_key = {roll_key[17:0], code} & kmask;
                    if (roll_fill < k)
                        roll_fill++;
                    if (k == 0)
                        a.status = STATUS_SKIPPED;
                    else if (roll_fill < k)
                        a.status = STATUS_PENDING;
                    else if (it.suffix_row >= mir_suffix_count)
                        a.status = STATUS_ROW_ERR;
                    else
                    begin
                        idx = int'(roll_key);
                        if (!dir_begin.exists(idx))
                        begin
                            dir_begin[idx] = it.suffix_row;
                            dir_end[idx]   = row_next;
                            if (fill_count != '1)
                                fill_count++;
                        end
                        else
                        begin
                            if (it.suffix_row < dir_begin[idx])
                                dir_begin[idx] = it.suffix_row;
                            if (row_next > dir_end[idx])
                                dir_end[idx] = row_next;
                        end
                        if (rec_count != '1)
                            rec_count++;
                        a.status = STATUS_RECORDED;
                    end
                end
            end
            ACT_QUERY:
            begin
                // only the first k symbols shape the key
                if (qry_fill < k)
                begin
                    if (!canon)
                        qry_bad = 1'b1;
                    else
                        qry_key = {qry_key[17:0], code};
                    qry_fill++;
                end
                if (it.query_last)
                begin
                    idx = int'(qry_key);
                    if (k == 0 || qry_fill < k || qry_bad)
                        a.status = STATUS_NONE;
                    else if (dir_begin.exists(idx))
                    begin
                        a.status = STATUS_HIT;
                        a.ibegin = dir_begin[idx];
                        a.iend   = dir_end[idx];
                    end
                    else
                        a.status = STATUS_EMPTY;
                    qry_key  = '0;
                    qry_fill = 0;
                    qry_bad  = 1'b0;
                end
                else
                    a.status = STATUS_PENDING;
            end
            default:
                a.status = STATUS_PENDING;
        endcase
        a.indexed  = rec_count;
        a.nonempty = fill_count;
        return a;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stalls and field-by-field compare
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, name,
                         want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            status_seen[m_axis_tuser]++;
            if (awaited_answers.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] result transaction with no answer outstanding", $realtime);
            end
            else
            begin
                head_answer = awaited_answers.pop_front();
                results_checked++;
                check_field("status", head_answer.status, m_axis_tuser);
                check_field("interval_begin", head_answer.ibegin, m_axis_tdata[31:0]);
                check_field("interval_end", head_answer.iend, m_axis_tdata[63:32]);
                check_field("indexed_total", head_answer.indexed, m_axis_tdata[103:64]);
                check_field("nonempty_total", head_answer.nonempty, m_axis_tdata[124:104]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side helpers
    // ------------------------------------------------------------------------
    function automatic dir_item_t make_item(logic [1:0] action, logic [7:0] sym, logic cstart,
                                            logic [31:0] row, logic last);
        dir_item_t it;
        it.action       = action;
        it.symbol       = sym;
        it.contig_start = cstart;
        it.suffix_row   = row;
        it.query_last   = last;
        return it;
    endfunction

    // One transaction; valid stays high afterwards unless a gap or drain lowers it
    task automatic send_item(dir_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, it.suffix_row, it.contig_start, it.symbol};
        s_axis_tuser  <= it.action;
        s_axis_tlast  <= it.query_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        awaited_answers.push_back(directory_answer(it));
        items_sent++;
    endtask

    // Hold off the sender until every answer is in, then let the pipe settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (awaited_answers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Writes all three registers; only called while idle
    task automatic set_config(logic [3:0] klen, logic [31:0] scount, logic [7:0] base);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_KMER_LENGTH;
        cfg_wdata <= {28'd0, klen};
        @(posedge clk);
        cfg_index <= CFG_SUFFIX_COUNT;
        cfg_wdata <= scount;
        @(posedge clk);
        cfg_index <= CFG_BASE_A_CODE;
        cfg_wdata <= {24'd0, base};
        @(posedge clk);
        cfg_we    <= 1'b0;
        mir_kmer_len     = klen;
        mir_suffix_count = scount;
        mir_base         = base;
    endtask

    // ------------------------------------------------------------------------
    // Random traffic: mostly genuine text runs and k-mer queries drawn from
    // recent text, with some broken queries and junk transactions mixed in
    // ------------------------------------------------------------------------
    task automatic run_random_items(int n_items);
        int         sent;
        int         pick;
        int         k;
        int         len;
        int         start;
        bit         from_trail;
        logic [7:0] sym;
        logic [31:0] row;
        logic       cstart;
        logic [7:0] pattern[$];
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            k    = active_kmer_len();
            if (pick < 68)
            begin
                // text symbol
                cstart = ($urandom_range(99) < 5);
                if ($urandom_range(99) < 92)
                    sym = mir_base + 8'($urandom_range(3));
                else
                    sym = 8'($urandom_range(255));
                if ($urandom_range(99) < 85)
                    row = $urandom_range(mir_suffix_count - 32'd1, 0);
                else
                    row = $urandom();
                if (cstart)
                    text_trail.delete();
                if (is_canonical(sym))
                begin
                    text_trail.push_back(sym);
                    if (text_trail.size() > 16)
                        void'(text_trail.pop_front());
                end
                else
                    text_trail.delete();
                send_item(make_item(ACT_TEXT, sym, cstart, row, 1'($urandom_range(1))));
                sent++;
            end
            else if (pick < 90)
            begin
                // query pattern, usually a window seen in recent text
                pick = $urandom_range(99);
                if (pick < 75)
                    len = k;
                else if (pick < 85)
                    len = k - 1;
                else
                    len = k + $urandom_range(1, 3);
                if (len < 1)
                    len = 1;
                from_trail = (k > 0) && (text_trail.size() >= k) && ($urandom_range(99) < 80);
                start = from_trail ? $urandom_range(text_trail.size() - k) : 0;
                pattern.delete();
                for (int i = 0; i < len; i++)
                begin
                    if (from_trail && i < k)
                        pattern.push_back(text_trail[start + i]);
                    else
                        pattern.push_back(mir_base + 8'($urandom_range(3)));
                end
                if ($urandom_range(99) < 6)
                    pattern[$urandom_range(len - 1)] = 8'($urandom_range(255));
                for (int i = 0; i < len; i++)
                    send_item(make_item(ACT_QUERY, pattern[i], 1'($urandom_range(1)), $urandom(),
                                        i == len - 1));
                sent += len;
            end
            else if (pick < 98)
            begin
                // junk: unused action, stray query symbol or stray text symbol
                pick = $urandom_range(2);
                if (pick == 0)
                    send_item(make_item(ACT_UNUSED, 8'($urandom_range(255)),
                                        1'($urandom_range(1)), $urandom(),
                                        1'($urandom_range(1))));
                else
                begin
                    send_item(make_item(pick == 1 ? ACT_QUERY : ACT_TEXT,
                                        8'($urandom_range(255)), 1'($urandom_range(1)),
                                        $urandom(), 1'($urandom_range(1))));
                    sent++;
                end
            end
            else
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // k of zero and k above the maximum both act as no index
    task automatic test_no_index();
        send_item(make_item(ACT_TEXT, 8'd0, 1'b0, 32'd0, 1'b0));
        send_item(make_item(ACT_QUERY, 8'd1, 1'b0, 32'd0, 1'b1));
        send_item(make_item(ACT_UNUSED, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1));
        drain_results();
        set_config(4'd15, 32'd1, 8'd0);
        send_item(make_item(ACT_TEXT, 8'd3, 1'b0, 32'd0, 1'b0));
        send_item(make_item(ACT_QUERY, 8'd2, 1'b0, 32'd0, 1'b1));
    endtask

    // recording, widening, row range, resets of the rolling key and lookups
    task automatic test_build_and_lookup();
        logic [7:0] b;
        b = 8'd65;
        drain_results();
        set_config(4'd2, 32'd100, b);
        send_item(make_item(ACT_TEXT, b, 1'b1, 32'd0, 1'b0));
        send_item(make_item(ACT_TEXT, b + 8'd1, 1'b0, 32'd5, 1'b0));
        send_item(make_item(ACT_TEXT, b + 8'd2, 1'b0, 32'd99, 1'b0));
        send_item(make_item(ACT_TEXT, b + 8'd3, 1'b0, 32'hFFFF_FFFF, 1'b0));
        send_item(make_item(ACT_TEXT, 8'd78, 1'b0, 32'd3, 1'b0));
        send_item(make_item(ACT_TEXT, b, 1'b0, 32'd1, 1'b0));
        send_item(make_item(ACT_TEXT, b + 8'd1, 1'b0, 32'd2, 1'b0));
        send_item(make_item(ACT_TEXT, b, 1'b1, 32'd7, 1'b1));
        send_item(make_item(ACT_TEXT, 8'd255, 1'b0, 32'd0, 1'b0));
        // hit
        send_item(make_item(ACT_QUERY, b, 1'b0, 32'd0, 1'b0));
        send_item(make_item(ACT_QUERY, b + 8'd1, 1'b0, 32'd0, 1'b1));
        // empty entry
        send_item(make_item(ACT_QUERY, b + 8'd3, 1'b0, 32'd0, 1'b0));
        send_item(make_item(ACT_QUERY, b + 8'd3, 1'b0, 32'd0, 1'b1));
        // short query
        send_item(make_item(ACT_QUERY, b + 8'd2, 1'b0, 32'd0, 1'b1));
        // non-canonical symbol inside the key
        send_item(make_item(ACT_QUERY, 8'd78, 1'b0, 32'd0, 1'b0));
        send_item(make_item(ACT_QUERY, b + 8'd1, 1'b0, 32'd0, 1'b1));
        // symbols past k are ignored
        send_item(make_item(ACT_QUERY, b + 8'd1, 1'b0, 32'd0, 1'b0));
        send_item(make_item(ACT_QUERY, b + 8'd2, 1'b0, 32'd0, 1'b0));
        send_item(make_item(ACT_QUERY, b + 8'd3, 1'b0, 32'd0, 1'b1));
    endtask

    // clear empties the directory and the counters
    task automatic test_clear();
        send_item(make_item(ACT_CLEAR, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1));
        send_item(make_item(ACT_QUERY, 8'd65, 1'b0, 32'd0, 1'b0));
        send_item(make_item(ACT_QUERY, 8'd66, 1'b0, 32'd0, 1'b1));
    endtask

    task automatic test_random_traffic(int sender_pct, int receiver_pct, logic [3:0] klen,
                                       logic [31:0] scount, logic [7:0] base, int n_items);
        drain_results();
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        set_config(klen, scount, base);
        text_trail.delete();
        run_random_items(n_items);
    endtask

    // clear with a loaded directory, then keep streaming through the pass
    task automatic test_clear_mid_stream(int n_items);
        send_item(make_item(ACT_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                            $urandom(), 1'($urandom_range(1))));
        text_trail.delete();
        run_random_items(n_items);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        send_idle_pct = 13;
        recv_idle_pct = 47;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_index();
        test_build_and_lookup();
        test_clear();

        test_random_traffic(13, 47, 4'd3, 32'd1000, 8'd65, 215);
        test_random_traffic(47, 13, 4'd10, 32'hFFFF_FFFF, 8'd252, 205);
        test_random_traffic(0, 0, 4'd1, 32'd50, 8'd0, 100);
        test_clear_mid_stream(60);
        test_random_traffic(0, 0, 4'd2, 32'd7, 8'd128, 50);

        drain_results();
        repeat (16) @(posedge clk);

        $display("Checked %0d results from %0d transactions over k = 0, 1, 2, 3, 10, 15",
                 results_checked, items_sent);
        $display("recorded %0d, skipped %0d, row errors %0d, hits %0d, empty %0d, none %0d, cleared %0d",
                 status_seen[STATUS_RECORDED], status_seen[STATUS_SKIPPED],
                 status_seen[STATUS_ROW_ERR], status_seen[STATUS_HIT],
                 status_seen[STATUS_EMPTY], status_seen[STATUS_NONE],
                 status_seen[STATUS_CLEARED]);
        if (mismatch_count == 0 && awaited_answers.size() == 0)
            $display("PASS kmer_interval_directory_top");
        else
            $display("FAIL kmer_interval_directory_top");
        $finish;
    end

endmodule
